FILE: rtl/tcre_pkg.sv
// ---------------------------------------------------------------------------
// tcre_pkg: shared types and codes for the register/ALU execute block
// Request payload types, decode classes and outcome codes.
// ---------------------------------------------------------------------------
package tcre_pkg;

    localparam logic [1:0] OUT_EXEC    = 2'd0;
    localparam logic [1:0] OUT_NOTHAND = 2'd1;
    localparam logic [1:0] OUT_ILLEGAL = 2'd2;

    localparam logic [1:0] CLS_EXEC    = 2'd0;
    localparam logic [1:0] CLS_NOTHAND = 2'd1;
    localparam logic [1:0] CLS_ILLEGAL = 2'd2;

    typedef struct packed {
        logic [7:0]  opcode;
        logic [15:0] immediate;
        logic [15:0] next_address;
    } tcre_in_t;

    typedef struct packed {
        logic [15:0] new_pc;
        logic [7:0]  reg_a;
        logic [7:0]  reg_b;
        logic [7:0]  reg_c;
        logic [7:0]  reg_d;
        logic [15:0] pair_hl;
        logic [7:0]  stack_ptr;
        logic [7:0]  flag_bits;
        logic [1:0]  outcome;
    } tcre_out_t;

    // classified request passed from front to back
    typedef struct packed {
        tcre_in_t   req;
        logic [1:0] cls;
    } tcre_cmd_t;

    function automatic logic [1:0] classify(input logic [7:0] op);
        logic [1:0] c;
        c = CLS_EXEC;
        if (op == 8'h01 || op == 8'h02 || (op >= 8'h08 && op <= 8'h0F) ||
            op == 8'h16 || op == 8'h17 || (op >= 8'h18 && op <= 8'h1F) ||
            (op >= 8'h54 && op <= 8'h5B) || (op >= 8'h60 && op <= 8'h6F) ||
            (op >= 8'h84 && op <= 8'h8F) || (op >= 8'hAC && op <= 8'hB7))
            c = CLS_NOTHAND;
        else if (op == 8'h00 || (op >= 8'h04 && op <= 8'h07) ||
                 (op >= 8'h70 && op <= 8'h73) || (op >= 8'hC4 && op <= 8'hC7) ||
                 (op >= 8'h11 && op <= 8'h15) || op == 8'hC0 || op == 8'hC1 ||
                 (op >= 8'h20 && op <= 8'h3F) ||
                 (op >= 8'h40 && op <= 8'h4F && op[3:2] != op[1:0]) ||
                 (op >= 8'h50 && op <= 8'h53) || (op >= 8'h5C && op <= 8'h5F) ||
                 (op >= 8'h74 && op <= 8'h83) || (op >= 8'h90 && op <= 8'hAB) ||
                 (op >= 8'hBA && op <= 8'hBF) || op == 8'hC2)
            c = CLS_EXEC;
        else
            c = CLS_ILLEGAL;
        return c;
    endfunction

endpackage

FILE: rtl/tcre_front.sv
// ---------------------------------------------------------------------------
// tcre_front: accept and classify
// Two-entry queue of classified requests between the input and the back end.
// ---------------------------------------------------------------------------
module tcre_front
    import tcre_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  tcre_in_t  in_req,
    output logic      full,
    output logic      cmd_valid,
    output tcre_cmd_t cmd,
    input  logic      cmd_take
);

    tcre_cmd_t  slot_reg [2];
    logic       rd_ptr_reg;
    logic       wr_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg].req <= in_req;
            slot_reg[wr_ptr_reg].cls <= classify(in_req.opcode);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (full && !cmd_take) |=> full)
        else $error("full dropped without a take");
    assert property (@(posedge clk) disable iff (!rst_n)
        (!cmd_valid && !push) |=> !cmd_valid)
        else $error("request appeared from nowhere");

endmodule

FILE: rtl/tcre_back.sv
// ---------------------------------------------------------------------------
// tcre_back: execute
// Holds the architectural registers and runs one request per cycle into an
// output register, while that register is empty or being popped.
// ---------------------------------------------------------------------------
module tcre_back
    import tcre_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  tcre_cmd_t cmd,
    output logic      cmd_take,
    output logic      empty,
    output tcre_out_t result,
    input  logic      pop
);

    logic [7:0]  r_reg [4];
    logic [15:0] hl_reg;
    logic [7:0]  sp_reg;
    logic [3:0]  f_reg;
    logic        res_valid_reg;
    tcre_out_t   res_reg;

    logic [7:0]  r_next [4];
    logic [15:0] hl_next;
    logic [7:0]  sp_next;
    logic [3:0]  f_next;
    logic [15:0] pc;

    logic [7:0]  op, im8, src, y, t;
    logic [15:0] im16, nxt, v16;
    logic [1:0]  ri;
    logic        cond, cy;
    logic [8:0]  s9;
    logic [16:0] s17;

    assign op   = cmd.req.opcode;
    assign im16 = cmd.req.immediate;
    assign im8  = im16[7:0];
    assign nxt  = cmd.req.next_address;
    assign ri   = op[1:0];
    assign src  = r_reg[ri];

    assign cmd_take = cmd_valid && (!res_valid_reg || pop);
    assign empty    = !res_valid_reg;
    assign result   = res_reg;

    always_comb
    begin
        case (ri)
            2'd0:    cond = 1'b1;
            2'd1:    cond = !f_reg[0];
            2'd2:    cond = f_reg[1];
            default: cond = f_reg[0];
        endcase
    end

    function automatic logic [3:0] fl8(input logic [7:0] v, input logic c);
        return {v[0], v[7], c, v == 8'd0};
    endfunction

    function automatic logic [3:0] fl16(input logic [15:0] v, input logic c);
        return {v[0], v[15], c, v == 16'd0};
    endfunction

    always_comb
    begin
        r_next  = r_reg;
        hl_next = hl_reg;
        sp_next = sp_reg;
        f_next  = f_reg;
        pc      = nxt;
        y       = 8'd0;
        t       = 8'd0;
        s9      = 9'd0;
        s17     = 17'd0;
        v16     = 16'd0;
        cy      = 1'b0;
        if (cmd.cls == CLS_EXEC)
        begin
            if (op inside {[8'h04:8'h07]})
            begin
                if (cond) pc = im16;
            end
            else if (op inside {[8'h70:8'h73]})
            begin
                if (cond) pc = hl_reg;
            end
            else if (op inside {[8'hC4:8'hC7]})
            begin
                if (cond) pc = nxt + {{8{im8[7]}}, im8};
            end
            else if (op == 8'h11)
                r_next[0] = hl_reg[15:8];
            else if (op == 8'h12)
                r_next[0] = hl_reg[7:0];
            else if (op == 8'h13 || op inside {[8'h20:8'h23]})
            begin
                s9 = {1'b0, r_reg[0]} + {1'b0, (op == 8'h13) ? im8 : src};
                r_next[0] = s9[7:0];
                f_next = fl8(s9[7:0], s9[8]);
            end
            else if (op == 8'h14 || op == 8'hC0)
            begin
                v16 = (op == 8'h14) ? {r_reg[0], r_reg[1]} : im16;
                s17 = {1'b0, hl_reg} + {1'b0, v16};
                hl_next = s17[15:0];
                f_next = fl16(s17[15:0], s17[16]);
            end
            else if (op == 8'hC1)
            begin
                hl_next = hl_reg - im16;
                f_next = fl16(hl_next, hl_reg < im16);
            end
            else if (op == 8'h15 || op inside {[8'h24:8'h27]})
            begin
                t = (op == 8'h15) ? im8 : src;
                y = r_reg[0] - t;
                r_next[0] = y;
                f_next = fl8(y, r_reg[0] < t);
            end
            else if (op inside {[8'h28:8'h33]})
            begin
                if (op == 8'h28)               y = r_reg[0] & im8;
                else if (op <= 8'h2B)          y = r_reg[0] & src;
                else if (op <= 8'h2F)          y = r_reg[0] ^ src;
                else if (op == 8'h30)          y = r_reg[0] | im8;
                else                           y = r_reg[0] | src;
                r_next[0] = y;
                f_next = fl8(y, 1'b0);
            end
            else if (op inside {[8'h34:8'h37]})
            begin
                y = src + 8'd1;
                r_next[ri] = y;
                f_next = fl8(y, y == 8'd0);
            end
            else if (op inside {[8'h38:8'h3B]})
            begin
                y = src - 8'd1;
                r_next[ri] = y;
                f_next = fl8(y, y == 8'hFF);
            end
            else if (op == 8'h3C)
            begin
                hl_next = hl_reg + 16'd1;
                f_next = fl16(hl_next, hl_next == 16'd0);
            end
            else if (op == 8'h3D)
            begin
                sp_next = sp_reg + 8'd1;
                f_next = fl8(sp_next, sp_next == 8'd0);
            end
            else if (op == 8'h3E)
            begin
                hl_next = hl_reg - 16'd1;
                f_next = fl16(hl_next, hl_next == 16'hFFFF);
            end
            else if (op == 8'h3F)
            begin
                sp_next = sp_reg - 8'd1;
                f_next = fl8(sp_next, sp_next == 8'hFF);
            end
            else if (op inside {[8'h40:8'h4F]})
                r_next[op[3:2]] = src;
            else if (op inside {[8'h50:8'h53]})
                r_next[ri] = im8;
            else if (op == 8'h5C)
                hl_next = im16;
            else if (op == 8'h5D)
                hl_next = {r_reg[0], r_reg[1]};
            else if (op == 8'h5E)
                hl_next = {r_reg[0], hl_reg[7:0]};
            else if (op == 8'h5F)
                hl_next = {hl_reg[15:8], r_reg[0]};
            else if (op inside {[8'h74:8'h77]})
            begin
                y = ~src;
                r_next[ri] = y;
                f_next = fl8(y, f_reg[1]);
            end
            else if (op inside {[8'h78:8'h7B]})
            begin
                y = {f_reg[1], src[7:1]};
                r_next[ri] = y;
                f_next = fl8(y, src[0]);
            end
            else if (op inside {[8'h7C:8'h7F]})
            begin
                y = {src[6:0], f_reg[1]};
                r_next[ri] = y;
                f_next = fl8(y, src[7]);
            end
            else if (op inside {[8'h80:8'h83]})
            begin
                t = (op == 8'h80) ? im8 : src;
                y = r_reg[0] ^ t;
                f_next = {y[0], y[7], r_reg[0] < t, r_reg[0] == t};
            end
            else if (op inside {[8'h90:8'h97]})
                f_next[0] = !r_reg[0][op[2:0]];
            else if (op inside {[8'h98:8'h9F]})
            begin
                y = r_reg[0] & ~(8'd1 << op[2:0]);
                r_next[0] = y;
                f_next[0] = (y == 8'd0);
                if (op[2:0] == 3'd0) f_next[3] = 1'b0;
                if (op[2:0] == 3'd7) f_next[2] = 1'b0;
            end
            else if (op inside {[8'hA0:8'hA7]})
            begin
                r_next[0] = r_reg[0] | (8'd1 << op[2:0]);
                f_next[0] = 1'b0;
                if (op[2:0] == 3'd0) f_next[3] = 1'b1;
                if (op[2:0] == 3'd7) f_next[2] = 1'b1;
            end
            else if (op inside {[8'hA8:8'hAB]})
            begin
                // flags only from the carry-in add
                t  = r_reg[0] + src;
                s9 = {1'b0, t} + {8'd0, f_reg[1]};
                r_next[0] = s9[7:0];
                f_next = fl8(s9[7:0], s9[8]);
            end
            else if (op inside {[8'hBA:8'hBF]})
            begin
                cy = (op[2:0] < 3'd4) ? f_reg[op[1:0]] : 1'b0;
                f_next[0] = !cy;
            end
            else if (op == 8'hC2)
            begin
                r_next[0] = hl_reg[15:8];
                r_next[1] = hl_reg[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg[0] <= 8'd0;
            r_reg[1] <= 8'd0;
            r_reg[2] <= 8'd0;
            r_reg[3] <= 8'd0;
            hl_reg <= 16'd0;
            sp_reg <= 8'd0;
            f_reg <= 4'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_take)
            begin
                r_reg  <= r_next;
                hl_reg <= hl_next;
                sp_reg <= sp_next;
                f_reg  <= f_next;
                res_valid_reg <= 1'b1;
            end
            else if (pop)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            res_reg.new_pc    <= pc;
            res_reg.reg_a     <= r_next[0];
            res_reg.reg_b     <= r_next[1];
            res_reg.reg_c     <= r_next[2];
            res_reg.reg_d     <= r_next[3];
            res_reg.pair_hl   <= hl_next;
            res_reg.stack_ptr <= sp_next;
            res_reg.flag_bits <= {4'd0, f_next};
            res_reg.outcome   <= (cmd.cls == CLS_NOTHAND) ? OUT_NOTHAND :
                                 (cmd.cls == CLS_ILLEGAL) ? OUT_ILLEGAL : OUT_EXEC;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd.cls != CLS_EXEC && cmd_take) |=>
        (hl_reg == $past(hl_reg) && sp_reg == $past(sp_reg) && f_reg == $past(f_reg)))
        else $error("state changed on a non-executed request");
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(res_reg)))
        else $error("stalled result lost");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |=> !empty)
        else $error("taken request produced no result");

endmodule

FILE: rtl/toy_cpu_register_alu_execute.sv
// ---------------------------------------------------------------------------
// toy_cpu_register_alu_execute: execute stage of a small 8-bit CPU
// Decoupled classify front end, register/ALU back end.
// ---------------------------------------------------------------------------
// Input channel: push/full carries one fetched instruction (opcode,
// immediate, next_address). Result channel: empty/pop carries the register
// file, flags, new_pc and outcome after that instruction.
// A request is queued, then executed into the result register. Throughput:
// one instruction per cycle while the result is empty or popped; the
// register/flag update is a single combinational step in the back end, fed
// from a two-entry classified queue. Reset clears A, B, C, D, HL, SP, flags,
// the queue and the result valid flag. When pop stays low, the result holds,
// the back end stops, the queue fills and full rises after two more pushes.
// ---------------------------------------------------------------------------
module toy_cpu_register_alu_execute
    import tcre_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  tcre_in_t  request,
    output logic      empty,
    input  logic      pop,
    output tcre_out_t result
);

    logic      cmd_valid;
    logic      cmd_take;
    tcre_cmd_t cmd;

    tcre_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_req    (request),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    tcre_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .result    (result),
        .pop       (pop)
    );

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for the register/ALU execute stage
// Drives fetched instructions through the push/full queue and checks every
// popped result (registers, flags, new_pc, outcome) against an in-bench
// predictor of the CPU state. Random gaps on both sides plus one long
// receiver hold-off to fill the block and stall its input.
// ---------------------------------------------------------------------------
module tb;
    import tcre_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 1700;
    localparam int HOLD_CYCLES    = 60;

    typedef struct {
        logic [7:0]  opcode;
        logic [15:0] immediate;
        logic [15:0] next_address;
        bit          pinned;   // expected value typed in below
        logic [15:0] want_pc;
        logic [7:0]  want_a;
        logic [7:0]  want_flags;
        logic [1:0]  want_outcome;
    } row_t;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    tcre_in_t  request;
    logic      empty;
    logic      pop;
    tcre_out_t result;

    toy_cpu_register_alu_execute dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .request (request),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    // predicted CPU state
    logic [7:0]  cpu_a;
    logic [7:0]  cpu_bcd [3];
    logic [15:0] cpu_hl;
    logic [7:0]  cpu_sp;
    logic [7:0]  cpu_f;

    tcre_out_t expected_results [$];
    int        mismatches;
    int        sent;
    int        received;
    int        idle_cycles;
    int        cnt_exec;
    int        cnt_nothand;
    int        cnt_illegal;
    int        cnt_taken;
    bit        hold_pop;
    row_t      rows [$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] reg_get(input logic [1:0] i);
        return (i == 2'd0) ? cpu_a : cpu_bcd[2'(i - 2'd1)];
    endfunction

    function automatic void reg_put(input logic [1:0] i, input logic [7:0] v);
        if (i == 2'd0)
            cpu_a = v;
        else
            cpu_bcd[2'(i - 2'd1)] = v;
    endfunction

    function automatic void flags8(input logic [7:0] y, input logic c);
        cpu_f[0] = (y == 8'd0);
        cpu_f[1] = c;
        cpu_f[2] = y[7];
        cpu_f[3] = y[0];
    endfunction

    function automatic void flags16(input logic [15:0] y, input logic c);
        cpu_f[0] = (y == 16'd0);
        cpu_f[1] = c;
        cpu_f[2] = y[15];
        cpu_f[3] = y[0];
    endfunction

    function automatic logic [7:0] add8(input logic [7:0] x, input logic [7:0] y);
        logic [8:0] s;
        s = {1'b0, x} + {1'b0, y};
        flags8(s[7:0], s[8]);
        return s[7:0];
    endfunction

    function automatic logic [7:0] sub8(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] d;
        d = x - y;
        flags8(d, x < y);
        return d;
    endfunction

    function automatic logic [7:0] logic8(input logic [7:0] y);
        flags8(y, 1'b0);
        return y;
    endfunction

    function automatic logic cond_met(input logic [1:0] c);
        case (c)
            2'd0: return 1'b1;
            2'd1: return ~cpu_f[0];
            2'd2: return cpu_f[1];
            default: return cpu_f[0];
        endcase
    endfunction

    function automatic void cpu_reset();
        cpu_a = '0;
        cpu_bcd[0] = '0;
        cpu_bcd[1] = '0;
        cpu_bcd[2] = '0;
        cpu_hl = '0;
        cpu_sp = '0;
        cpu_f = '0;
    endfunction

    // executes one instruction on the predicted state, returns the result
    function automatic tcre_out_t execute_instr(input tcre_in_t rq);
        tcre_out_t   r;
        logic [7:0]  op;
        logic [7:0]  im8;
        logic [1:0]  ri;
        logic [15:0] pc;
        logic [1:0]  oc;
        logic [16:0] s17;
        logic [15:0] v16;
        logic [7:0]  v;
        logic [7:0]  y;
        logic        cin;
        op = rq.opcode;
        im8 = rq.immediate[7:0];
        ri = op[1:0];
        pc = rq.next_address;
        oc = OUT_EXEC;
        if (op == 8'h00) begin
        end else if (op >= 8'h04 && op <= 8'h07) begin
            if (cond_met(ri)) pc = rq.immediate;
        end else if (op >= 8'h70 && op <= 8'h73) begin
            if (cond_met(ri)) pc = cpu_hl;
        end else if (op >= 8'hC4 && op <= 8'hC7) begin
            if (cond_met(ri)) pc = rq.next_address + {{8{im8[7]}}, im8};
        end else if (op == 8'h01 || op == 8'h02 || (op >= 8'h08 && op <= 8'h0F) ||
                     (op >= 8'h16 && op <= 8'h1F) || (op >= 8'h54 && op <= 8'h5B) ||
                     (op >= 8'h60 && op <= 8'h6F) || (op >= 8'h84 && op <= 8'h8F) ||
                     (op >= 8'hAC && op <= 8'hB7)) begin
            oc = OUT_NOTHAND;
        end else if (op == 8'h11) begin
            cpu_a = cpu_hl[15:8];
        end else if (op == 8'h12) begin
            cpu_a = cpu_hl[7:0];
        end else if (op == 8'h13) begin
            cpu_a = add8(cpu_a, im8);
        end else if (op == 8'h14 || op == 8'hC0) begin
            v16 = (op == 8'h14) ? {cpu_a, cpu_bcd[0]} : rq.immediate;
            s17 = {1'b0, cpu_hl} + {1'b0, v16};
            cpu_hl = s17[15:0];
            flags16(cpu_hl, s17[16]);
        end else if (op == 8'hC1) begin
            cin = cpu_hl < rq.immediate;
            cpu_hl = cpu_hl - rq.immediate;
            flags16(cpu_hl, cin);
        end else if (op == 8'h15) begin
            cpu_a = sub8(cpu_a, im8);
        end else if (op >= 8'h20 && op <= 8'h23) begin
            cpu_a = add8(cpu_a, reg_get(ri));
        end else if (op >= 8'h24 && op <= 8'h27) begin
            cpu_a = sub8(cpu_a, reg_get(ri));
        end else if (op == 8'h28) begin
            cpu_a = logic8(cpu_a & im8);
        end else if (op >= 8'h29 && op <= 8'h2B) begin
            cpu_a = logic8(cpu_a & reg_get(ri));
        end else if (op >= 8'h2C && op <= 8'h2F) begin
            cpu_a = logic8(cpu_a ^ reg_get(ri));
        end else if (op == 8'h30) begin
            cpu_a = logic8(cpu_a | im8);
        end else if (op >= 8'h31 && op <= 8'h33) begin
            cpu_a = logic8(cpu_a | reg_get(ri));
        end else if (op >= 8'h34 && op <= 8'h37) begin
            y = reg_get(ri) + 8'd1;
            reg_put(ri, y);
            flags8(y, y == 8'h00);
        end else if (op >= 8'h38 && op <= 8'h3B) begin
            y = reg_get(ri) - 8'd1;
            reg_put(ri, y);
            flags8(y, y == 8'hFF);
        end else if (op == 8'h3C) begin
            cpu_hl = cpu_hl + 16'd1;
            flags16(cpu_hl, cpu_hl == 16'h0000);
        end else if (op == 8'h3D) begin
            cpu_sp = cpu_sp + 8'd1;
            flags8(cpu_sp, cpu_sp == 8'h00);
        end else if (op == 8'h3E) begin
            cpu_hl = cpu_hl - 16'd1;
            flags16(cpu_hl, cpu_hl == 16'hFFFF);
        end else if (op == 8'h3F) begin
            cpu_sp = cpu_sp - 8'd1;
            flags8(cpu_sp, cpu_sp == 8'hFF);
        end else if (op >= 8'h40 && op <= 8'h4F && op[3:2] != ri) begin
            reg_put(op[3:2], reg_get(ri));
        end else if (op >= 8'h50 && op <= 8'h53) begin
            reg_put(ri, im8);
        end else if (op == 8'h5C) begin
            cpu_hl = rq.immediate;
        end else if (op == 8'h5D) begin
            cpu_hl = {cpu_a, cpu_bcd[0]};
        end else if (op == 8'h5E) begin
            cpu_hl = {cpu_a, cpu_hl[7:0]};
        end else if (op == 8'h5F) begin
            cpu_hl = {cpu_hl[15:8], cpu_a};
        end else if (op >= 8'h74 && op <= 8'h77) begin
            y = ~reg_get(ri);
            reg_put(ri, y);
            cpu_f[0] = (y == 8'd0);
            cpu_f[2] = y[7];
            cpu_f[3] = y[0];
        end else if (op >= 8'h78 && op <= 8'h7B) begin
            v = reg_get(ri);
            y = {cpu_f[1], v[7:1]};
            reg_put(ri, y);
            flags8(y, v[0]);
        end else if (op >= 8'h7C && op <= 8'h7F) begin
            v = reg_get(ri);
            y = {v[6:0], cpu_f[1]};
            reg_put(ri, y);
            flags8(y, v[7]);
        end else if (op >= 8'h80 && op <= 8'h83) begin
            v = (op == 8'h80) ? im8 : reg_get(ri);
            cpu_f[0] = (cpu_a == v);
            cpu_f[1] = (cpu_a < v);
            cpu_f[2] = cpu_a[7] ^ v[7];
            cpu_f[3] = cpu_a[0] ^ v[0];
        end else if (op >= 8'h90 && op <= 8'h97) begin
            cpu_f[0] = ~cpu_a[op[2:0]];
        end else if (op >= 8'h98 && op <= 8'h9F) begin
            cpu_a[op[2:0]] = 1'b0;
            cpu_f[0] = (cpu_a == 8'd0);
            if (op[2:0] == 3'd0) cpu_f[3] = 1'b0;
            if (op[2:0] == 3'd7) cpu_f[2] = 1'b0;
        end else if (op >= 8'hA0 && op <= 8'hA7) begin
            cpu_a[op[2:0]] = 1'b1;
            cpu_f[0] = 1'b0;
            if (op[2:0] == 3'd0) cpu_f[3] = 1'b1;
            if (op[2:0] == 3'd7) cpu_f[2] = 1'b1;
        end else if (op >= 8'hA8 && op <= 8'hAB) begin
            // flags end up from the carry-in add only
            cin = cpu_f[1];
            cpu_a = add8(cpu_a, reg_get(ri));
            cpu_a = add8(cpu_a, {7'd0, cin});
        end else if (op >= 8'hBA && op <= 8'hBF) begin
            cpu_f[0] = ~cpu_f[op[2:0]];
        end else if (op == 8'hC2) begin
            cpu_a = cpu_hl[15:8];
            cpu_bcd[0] = cpu_hl[7:0];
        end else begin
            oc = OUT_ILLEGAL;
        end
        r.new_pc = pc;
        r.reg_a = cpu_a;
        r.reg_b = cpu_bcd[0];
        r.reg_c = cpu_bcd[1];
        r.reg_d = cpu_bcd[2];
        r.pair_hl = cpu_hl;
        r.stack_ptr = cpu_sp;
        r.flag_bits = cpu_f;
        r.outcome = oc;
        return r;
    endfunction

    function automatic int short_or_long_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(8, 30);
        return $urandom_range(0, 3);
    endfunction

    // biased so most items are executed ops that hit the flag/branch corners
    function automatic logic [7:0] pick_opcode();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 8'($urandom_range(0, 255));
        if (k == 1) return 8'($urandom_range(8'h04, 8'h07));
        if (k == 2) return 8'($urandom_range(8'hC4, 8'hC7));
        if (k == 3) return 8'($urandom_range(8'h50, 8'h53));
        if (k == 4) return 8'($urandom_range(8'hA8, 8'hAB));
        return 8'($urandom_range(8'h11, 8'hC7));
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h0080;
            3: return 16'h007F;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic void add_row(input logic [7:0] op, input logic [15:0] im,
                                    input logic [15:0] nx, input bit pin,
                                    input logic [15:0] pc, input logic [7:0] a,
                                    input logic [7:0] f, input logic [1:0] oc);
        row_t r;
        r.opcode = op;
        r.immediate = im;
        r.next_address = nx;
        r.pinned = pin;
        r.want_pc = pc;
        r.want_a = a;
        r.want_flags = f;
        r.want_outcome = oc;
        rows.push_back(r);
    endfunction

    // push stays high across back-to-back requests, drops only for a gap
    task automatic send_instr(input logic [7:0] op, input logic [15:0] im,
                              input logic [15:0] nx);
        tcre_in_t rq;
        int gap;
        gap = short_or_long_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rq.opcode = op;
        rq.immediate = im;
        rq.next_address = nx;
        push <= 1'b1;
        request <= rq;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    // prediction happens at acceptance, in order
    always @(posedge clk)
    begin
        tcre_out_t e;
        if (rst_n && push && !full) begin
            e = execute_instr(request);
            expected_results.push_back(e);
            sent++;
            if (e.outcome == OUT_EXEC) cnt_exec++;
            else if (e.outcome == OUT_NOTHAND) cnt_nothand++;
            else cnt_illegal++;
            if (e.new_pc != request.next_address) cnt_taken++;
        end
    end

    always @(posedge clk)
    begin
        tcre_out_t e;
        if (rst_n && pop && !empty) begin
            received++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", result);
            end else begin
                e = expected_results.pop_front();
                if (result !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected %p, got %p", received, e, result);
                end
            end
        end
    end

    // receiver: random pop with gaps, long hold-off on request
    initial
    begin
        int gap;
        pop <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_pop) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_pop = 1'b0;
            end
            gap = short_or_long_gap();
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap - 1) @(posedge clk);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress, %0d results outstanding",
                     expected_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int wait_cycles;
        push = 1'b0;
        request = '0;
        rst_n = 1'b0;
        mismatches = 0;
        sent = 0;
        received = 0;
        idle_cycles = 0;
        cnt_exec = 0;
        cnt_nothand = 0;
        cnt_illegal = 0;
        cnt_taken = 0;
        hold_pop = 1'b0;
        cpu_reset();

        // after reset: pinned rows; the rest checked by the predictor
        add_row(8'h00, 16'hFFFF, 16'h1234, 1'b1, 16'h1234, 8'h00, 8'h00, OUT_EXEC);
        add_row(8'h01, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 8'h00, 8'h00, OUT_NOTHAND);
        add_row(8'h03, 16'h0000, 16'h0000, 1'b1, 16'h0000, 8'h00, 8'h00, OUT_ILLEGAL);
        add_row(8'h45, 16'h0000, 16'h0010, 1'b1, 16'h0010, 8'h00, 8'h00, OUT_ILLEGAL);
        add_row(8'h13, 16'h00FF, 16'h0002, 1'b1, 16'h0002, 8'hFF, 8'h0C, OUT_EXEC);
        add_row(8'h13, 16'hFF01, 16'h0004, 1'b1, 16'h0004, 8'h00, 8'h03, OUT_EXEC);
        add_row(8'h05, 16'hBEEF, 16'h0007, 1'b1, 16'h0007, 8'h00, 8'h03, OUT_EXEC);
        add_row(8'h07, 16'hBEEF, 16'h0007, 1'b1, 16'hBEEF, 8'h00, 8'h03, OUT_EXEC);
        add_row(8'hC6, 16'h0080, 16'h0040, 1'b1, 16'hFFC0, 8'h00, 8'h03, OUT_EXEC);
        add_row(8'hC4, 16'h007F, 16'hFFF0, 1'b1, 16'h006F, 8'h00, 8'h03, OUT_EXEC);
        add_row(8'h50, 16'h00FF, 16'h0000, 1'b0, 16'h0000, 8'h00, 8'h00, OUT_EXEC);
        add_row(8'h51, 16'h0001, 16'h0000, 1'b0, 16'h0000, 8'h00, 8'h00, OUT_EXEC);
        add_row(8'hA8, 16'h0000, 16'h0000, 1'b0, 16'h0000, 8'h00, 8'h00, OUT_EXEC);
        add_row(8'h5C, 16'hFFFF, 16'h0000, 1'b0, 16'h0000, 8'h00, 8'h00, OUT_EXEC);
        add_row(8'h3C, 16'h0000, 16'h0000, 1'b0, 16'h0000, 8'h00, 8'h00, OUT_EXEC);
        add_row(8'h72, 16'h0000, 16'h8000, 1'b0, 16'h0000, 8'h00, 8'h00, OUT_EXEC);
        add_row(8'h3F, 16'h0000, 16'h0000, 1'b0, 16'h0000, 8'h00, 8'h00, OUT_EXEC);
        add_row(8'hC1, 16'h0001, 16'h0000, 1'b0, 16'h0000, 8'h00, 8'h00, OUT_EXEC);
        add_row(8'h7C, 16'h0000, 16'h0000, 1'b0, 16'h0000, 8'h00, 8'h00, OUT_EXEC);
        add_row(8'h78, 16'h0000, 16'h0000, 1'b0, 16'h0000, 8'h00, 8'h00, OUT_EXEC);
        add_row(8'h80, 16'h0080, 16'h0000, 1'b0, 16'h0000, 8'h00, 8'h00, OUT_EXEC);
        add_row(8'h9F, 16'h0000, 16'h0000, 1'b0, 16'h0000, 8'h00, 8'h00, OUT_EXEC);
        add_row(8'hA7, 16'h0000, 16'h0000, 1'b0, 16'h0000, 8'h00, 8'h00, OUT_EXEC);
        add_row(8'hBB, 16'h0000, 16'h0000, 1'b0, 16'h0000, 8'h00, 8'h00, OUT_EXEC);
        add_row(8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000, 8'h00, 8'h00, OUT_ILLEGAL);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pinned rows are cross-checked against the predictor on the fly
        foreach (rows[i]) begin
            if (rows[i].pinned) begin
                tcre_out_t p;
                tcre_in_t  q;
                q.opcode = rows[i].opcode;
                q.immediate = rows[i].immediate;
                q.next_address = rows[i].next_address;
                p = execute_instr(q);
                if (p.new_pc !== rows[i].want_pc || p.reg_a !== rows[i].want_a ||
                    p.flag_bits !== rows[i].want_flags ||
                    p.outcome !== rows[i].want_outcome) begin
                    mismatches++;
                    $display("table row %0d: typed value disagrees with predictor", i);
                end
            end
        end
        cpu_reset();
        foreach (rows[i])
            send_instr(rows[i].opcode, rows[i].immediate, rows[i].next_address);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) hold_pop = 1'b1;
            send_instr(pick_opcode(), pick_word(), pick_word());
        end
        push <= 1'b0;

        wait_cycles = 0;
        while (expected_results.size() != 0 && wait_cycles < 4 * WATCHDOG_LIMIT) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (10) @(posedge clk);

        $display("sent %0d instructions: %0d executed, %0d not handled, %0d illegal",
                 sent, cnt_exec, cnt_nothand, cnt_illegal);
        $display("%0d branches taken, %0d results checked, %0d mismatches",
                 cnt_taken, received, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
